@@ rtl/core/wiamd_pkg.sv @@
// ----------------------------------------------------------------------------
// wiamd_pkg
// Shared types and constants for the wide integer add/sub/mul/divmod unit.
// ----------------------------------------------------------------------------
package wiamd_pkg;

    // width of the payload fields on the ports
    localparam int FIELD_BITS   = 64;

    // operand width used by the arithmetic, at most FIELD_BITS
    localparam int OPERAND_BITS = 64;

    // iteration counter for multiply and divide
    localparam int CNT_BITS     = $clog2(OPERAND_BITS);

    // width of the shared adder: one guard bit over the operand
    localparam int ADD_BITS     = OPERAND_BITS + 1;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

endpackage

@@ rtl/core/wiamd_if.sv @@
// ----------------------------------------------------------------------------
// wiamd_if
// Valid/ready channels of the arithmetic unit: operand items in, result
// items out.
// ----------------------------------------------------------------------------
interface wiamd_cmd_if
    import wiamd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    action_t               action;
    logic [FIELD_BITS-1:0] operand_a;
    logic [FIELD_BITS-1:0] operand_b;

    modport source (output valid, output action, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input action, input operand_a, input operand_b,
                    output ready);
endinterface

interface wiamd_rsp_if
    import wiamd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] value;
    logic [FIELD_BITS-1:0] leftover;
    logic                  divide_by_zero;

    modport source (output valid, output value, output leftover, output divide_by_zero,
                    input ready);
    modport sink   (input valid, input value, input leftover, input divide_by_zero,
                    output ready);
endinterface

@@ rtl/core/wiamd_adder.sv @@
// ----------------------------------------------------------------------------
// wiamd_adder
// Shared adder of the unit, one guard bit wide over the operand, with carry
// in and carry out. Serves add, subtract, multiply steps and divide compares.
// ----------------------------------------------------------------------------
module wiamd_adder
    import wiamd_pkg::*;
(
    input  logic [ADD_BITS-1:0] x,
    input  logic [ADD_BITS-1:0] y,
    input  logic                cin,
    output logic [ADD_BITS-1:0] sum,
    output logic                cout
);

    // full-width add with carry out
    assign {cout, sum} = {1'b0, x} + {1'b0, y} + {{ADD_BITS{1'b0}}, cin};

endmodule

@@ rtl/core/wide_integer_add_sub_mul_divmod.sv @@
// ----------------------------------------------------------------------------
// wide_integer_add_sub_mul_divmod
// Unsigned arithmetic unit: add, subtract, shift-and-add multiply and
// restoring divide with remainder, all on one shared adder.
// Steps: add/subtract go from accept through S_ADD to S_DONE; multiply and
//   divide loop in S_MUL or S_DIV, one operand bit per cycle through the
//   single adder, then S_DONE; a divide by zero goes straight to S_DONE.
//   S_DONE loads the output register once it is free; a stalled result holds
//   the next one in its done step. A new item is taken only in idle, while
//   the previous result may still wait in the output register.
// Reset: asynchronous, active low; clears the sequencer, datapath and results.
// ----------------------------------------------------------------------------
module wide_integer_add_sub_mul_divmod
    import wiamd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    wiamd_cmd_if.sink    cmd,
    wiamd_rsp_if.source  rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    action_t                 op_reg, op_next;
    logic                    dz_reg, dz_next;
    logic [OPERAND_BITS-1:0] x_reg, x_next;
    logic [OPERAND_BITS-1:0] y_reg, y_next;
    logic [OPERAND_BITS-1:0] acc_reg, acc_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;

    logic [FIELD_BITS-1:0]   value_reg, value_next;
    logic [FIELD_BITS-1:0]   leftover_reg, leftover_next;
    logic                    dzout_reg, dzout_next;

    logic [ADD_BITS-1:0]     add_x, add_y, add_sum;
    logic                    add_cin, add_cout;
    logic [ADD_BITS-1:0]     rem_shift;
    logic                    accept, rsp_free, last_step;

    assign accept    = cmd.valid && cmd.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign last_step = (cnt_reg == CNT_BITS'(OPERAND_BITS - 1));

    // partial remainder shifted left with the next dividend bit
    assign rem_shift = {acc_reg, x_reg[OPERAND_BITS-1]};

    wiamd_adder u_adder (
        .x    (add_x),
        .y    (add_y),
        .cin  (add_cin),
        .sum  (add_sum),
        .cout (add_cout)
    );

    // adder operand select per step
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_cin = 1'b0;
        case (state_reg)
            S_ADD:
            begin
                add_x   = {1'b0, x_reg};
                add_y   = (op_reg == ACT_SUB) ? ~{1'b0, y_reg} : {1'b0, y_reg};
                add_cin = (op_reg == ACT_SUB);
            end
            S_MUL:
            begin
                add_x = {1'b0, acc_reg};
                add_y = {1'b0, x_reg};
            end
            S_DIV:
            begin
                add_x   = rem_shift;
                add_y   = ~{1'b0, y_reg};
                add_cin = 1'b1;
            end
            default:
            begin
                add_x   = '0;
            end
        endcase
    end

    // sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        op_next        = op_reg;
        dz_next        = dz_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        value_next     = value_reg;
        leftover_next  = leftover_reg;
        dzout_next     = dzout_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = cmd.action;
                    x_next   = cmd.operand_a[OPERAND_BITS-1:0];
                    y_next   = cmd.operand_b[OPERAND_BITS-1:0];
                    acc_next = '0;
                    cnt_next = '0;
                    dz_next  = 1'b0;
                    case (cmd.action)
                        ACT_ADD, ACT_SUB: state_next = S_ADD;
                        ACT_MUL:          state_next = S_MUL;
                        ACT_DIV:
                        begin
                            if (cmd.operand_b[OPERAND_BITS-1:0] == '0)
                            begin
                                dz_next    = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_DIV;
                            end
                        end
                        default:          state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                acc_next   = add_sum[OPERAND_BITS-1:0];
                state_next = S_DONE;
            end
            S_MUL:
            begin
                // add shifted multiplicand where the multiplier bit is set
                if (y_reg[0])
                begin
                    acc_next = add_sum[OPERAND_BITS-1:0];
                end
                x_next   = {x_reg[OPERAND_BITS-2:0], 1'b0};
                y_next   = {1'b0, y_reg[OPERAND_BITS-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                // restore unless the trial subtract stayed non-negative
                acc_next = add_cout ? add_sum[OPERAND_BITS-1:0]
                                    : rem_shift[OPERAND_BITS-1:0];
                x_next   = {x_reg[OPERAND_BITS-2:0], add_cout};
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    dzout_next     = dz_reg;
                    if (dz_reg)
                    begin
                        value_next    = '0;
                        leftover_next = '0;
                    end
                    else if (op_reg == ACT_DIV)
                    begin
                        value_next    = FIELD_BITS'(x_reg);
                        leftover_next = FIELD_BITS'(acc_reg);
                    end
                    else
                    begin
                        value_next    = FIELD_BITS'(acc_reg);
                        leftover_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, datapath and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            op_reg        <= ACT_ADD;
            dz_reg        <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            value_reg     <= '0;
            leftover_reg  <= '0;
            dzout_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            op_reg        <= op_next;
            dz_reg        <= dz_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            value_reg     <= value_next;
            leftover_reg  <= leftover_next;
            dzout_reg     <= dzout_next;
        end
    end

    assign cmd.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.value          = value_reg;
    assign rsp.leftover       = leftover_reg;
    assign rsp.divide_by_zero = dzout_reg;

endmodule
